// ----- rtl/lkvc_pkg.sv -----
// Package: shared constants and types for the LRU key-value cache.
package lkvc_pkg;

  // Default geometry
  localparam int Entries   = 16;
  localparam int KeyBits   = 32;
  localparam int ValueBits = 32;

  // Capacity register
  localparam int              CapW     = 5;
  localparam logic [CapW-1:0] CapReset = 5'd16;

  // Request opcodes
  typedef enum logic {
    OpGet = 1'b0,
    OpPut = 1'b1
  } op_e;

endpackage

// ----- rtl/lkvc_if.sv -----
// Interfaces: request, response and capacity-write channels of the cache.

// Request channel: one get or put item
interface lkvc_req_if #(
  parameter int KEY_BITS   = lkvc_pkg::KeyBits,
  parameter int VALUE_BITS = lkvc_pkg::ValueBits
);
  logic                         valid;
  logic                         ready;
  logic                         opcode;
  logic signed [KEY_BITS-1:0]   key;
  logic signed [VALUE_BITS-1:0] value;

  modport source (output valid, opcode, key, value, input ready);
  modport sink   (input valid, opcode, key, value, output ready);
endinterface

// Response channel: one item per get
interface lkvc_rsp_if #(
  parameter int VALUE_BITS = lkvc_pkg::ValueBits
);
  logic                         valid;
  logic                         ready;
  logic                         hit;
  logic signed [VALUE_BITS-1:0] read_value;

  modport source (output valid, hit, read_value, input ready);
  modport sink   (input valid, hit, read_value, output ready);
endinterface

// Capacity write channel
interface lkvc_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [lkvc_pkg::CapW-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ----- rtl/lkvc_lookup.sv -----
// Lookup: parallel key match, free-slot pick and LRU victim pick.
module lkvc_lookup #(
  parameter int ENTRIES  = lkvc_pkg::Entries,
  parameter int KEY_BITS = lkvc_pkg::KeyBits,
  localparam int AgeW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  localparam int UsedW   = $clog2(ENTRIES + 1)
) (
  input  logic [ENTRIES-1:0]        entry_valid_i,
  input  logic [KEY_BITS-1:0]       entry_key_i [ENTRIES],
  input  logic [AgeW-1:0]           entry_age_i [ENTRIES],
  input  logic [UsedW-1:0]          used_count_i,
  input  logic [lkvc_pkg::CapW-1:0] capacity_i,
  input  logic [KEY_BITS-1:0]       key_i,
  output logic [ENTRIES-1:0]        hit_oh_o,
  output logic [ENTRIES-1:0]        slot_oh_o,
  output logic                      fill_new_o
);

  localparam int CmpW = (UsedW > lkvc_pkg::CapW) ? UsedW : lkvc_pkg::CapW;

  logic [ENTRIES-1:0] free_vec;
  logic [ENTRIES-1:0] first_free;
  logic [ENTRIES-1:0] victim_oh;
  logic [AgeW-1:0]    oldest_age;
  logic [UsedW-1:0]   used_m1;
  logic [CmpW-1:0]    used_ext;
  logic [CmpW-1:0]    cap_ext;
  logic               below_cap;
  logic               below_entries;

  // Key compare in every entry at once
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      hit_oh_o[i] = entry_valid_i[i] && (entry_key_i[i] == key_i);
    end
  end

  // Lowest free entry
  assign free_vec   = ~entry_valid_i;
  assign first_free = free_vec & (~free_vec + ENTRIES'(1));

  // Valid ages form 0..used-1, so the oldest entry has age used-1
  assign used_m1    = used_count_i - UsedW'(1);
  assign oldest_age = used_m1[AgeW-1:0];

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      victim_oh[i] = entry_valid_i[i] && (entry_age_i[i] == oldest_age);
    end
  end

  // Room check against the clamped capacity (zero acts as one)
  assign used_ext      = CmpW'(used_count_i);
  assign cap_ext       = CmpW'(capacity_i);
  assign below_entries = used_count_i < UsedW'(ENTRIES);
  assign below_cap     = (used_ext < cap_ext) ||
                         ((capacity_i == '0) && (used_count_i == '0));

  assign fill_new_o = below_entries && below_cap;
  assign slot_oh_o  = fill_new_o ? first_free : victim_oh;

endmodule

// ----- rtl/lru_key_value_cache_unit.sv -----
// Top level: fully associative key-value cache with true LRU replacement.
//
//  channel | dir | handshake       | payload
//  --------+-----+-----------------+---------------------------------
//  req     | in  | valid / ready   | opcode, key, value
//  rsp     | out | valid / ready   | hit, read_value (gets only)
//  cfg     | in  | valid / ready   | data = capacity (always ready)
//
// One item per cycle while no get waits on the result register: the match,
// LRU update and result capture all happen as an item leaves the input
// register; a get result is registered. All state updates land as the item
// leaves, so back-to-back items see each other's effects.
// Reset empties the cache and sets capacity to 16; no clearing pass.
// A get waits in the input register while the result register is full and
// not being taken; puts never wait on the response side.
module lru_key_value_cache_unit #(
  parameter int ENTRIES    = lkvc_pkg::Entries,
  parameter int KEY_BITS   = lkvc_pkg::KeyBits,
  parameter int VALUE_BITS = lkvc_pkg::ValueBits
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  lkvc_req_if.sink   req,
  lkvc_rsp_if.source rsp,
  lkvc_cfg_if.sink   cfg
);

  localparam int AgeW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int UsedW = $clog2(ENTRIES + 1);

  // Entry storage
  logic [ENTRIES-1:0]    valid_q;
  logic [KEY_BITS-1:0]   key_q   [ENTRIES];
  logic [VALUE_BITS-1:0] value_q [ENTRIES];
  logic [AgeW-1:0]       age_q   [ENTRIES];
  logic [UsedW-1:0]      used_q;
  logic [lkvc_pkg::CapW-1:0] cap_q;

  // Input register
  logic                  s1_valid_q;
  lkvc_pkg::op_e         s1_op_q;
  logic [KEY_BITS-1:0]   s1_key_q;
  logic [VALUE_BITS-1:0] s1_value_q;

  // Result register
  logic                  out_valid_q;
  logic                  out_hit_q;
  logic [VALUE_BITS-1:0] out_value_q;

  logic [ENTRIES-1:0]    hit_oh;
  logic [ENTRIES-1:0]    slot_oh;
  logic                  fill_new;
  logic                  hit;
  logic [AgeW-1:0]       hit_age;
  logic [VALUE_BITS-1:0] hit_value;
  logic                  out_free;
  logic                  s1_fire;
  logic                  is_put;
  logic                  get_fire;
  logic                  put_fire;
  logic                  in_fire;

  // Handshakes
  assign is_put    = (s1_op_q == lkvc_pkg::OpPut);
  assign out_free  = !out_valid_q || rsp.ready;
  assign s1_fire   = s1_valid_q && (is_put || out_free);
  assign get_fire  = s1_fire && !is_put;
  assign put_fire  = s1_fire && is_put;
  assign req.ready = !s1_valid_q || s1_fire;
  assign in_fire   = req.valid && req.ready;
  assign cfg.ready = 1'b1;

  lkvc_lookup #(
    .ENTRIES  (ENTRIES),
    .KEY_BITS (KEY_BITS)
  ) u_lookup (
    .entry_valid_i (valid_q),
    .entry_key_i   (key_q),
    .entry_age_i   (age_q),
    .used_count_i  (used_q),
    .capacity_i    (cap_q),
    .key_i         (s1_key_q),
    .hit_oh_o      (hit_oh),
    .slot_oh_o     (slot_oh),
    .fill_new_o    (fill_new)
  );

  // Age and value of the matching entry
  assign hit = |hit_oh;
  always_comb begin
    hit_age   = '0;
    hit_value = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit_oh[i]) begin
        hit_age   = hit_age | age_q[i];
        hit_value = hit_value | value_q[i];
      end
    end
  end

  // Capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= lkvc_pkg::CapReset;
    end else if (cfg.valid && cfg.ready) begin
      cap_q <= cfg.data;
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (req.ready) begin
      s1_valid_q <= req.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_op_q    <= lkvc_pkg::op_e'(req.opcode);
      s1_key_q   <= req.key;
      s1_value_q <= req.value;
    end
  end

  // Valid bits, ages and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      used_q  <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        age_q[i] <= '0;
      end
    end else if (s1_fire) begin
      if (hit) begin
        // touch: younger entries age by one, the hit becomes most recent
        for (int i = 0; i < ENTRIES; i++) begin
          if (hit_oh[i]) begin
            age_q[i] <= '0;
          end else if (valid_q[i] && (age_q[i] < hit_age)) begin
            age_q[i] <= age_q[i] + AgeW'(1);
          end
        end
      end else if (is_put) begin
        // new key: all others age, the chosen slot becomes most recent
        for (int i = 0; i < ENTRIES; i++) begin
          if (slot_oh[i]) begin
            valid_q[i] <= 1'b1;
            age_q[i]   <= '0;
          end else if (valid_q[i]) begin
            age_q[i] <= age_q[i] + AgeW'(1);
          end
        end
        if (fill_new) begin
          used_q <= used_q + UsedW'(1);
        end
      end
    end
  end

  // Keys and values
  always_ff @(posedge clk_i) begin
    if (put_fire) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (hit_oh[i]) begin
          value_q[i] <= s1_value_q;
        end else if (!hit && slot_oh[i]) begin
          key_q[i]   <= s1_key_q;
          value_q[i] <= s1_value_q;
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (get_fire) begin
      out_valid_q <= 1'b1;
    end else if (rsp.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (get_fire) begin
      out_hit_q   <= hit;
      out_value_q <= hit ? hit_value : '0;
    end
  end

  assign rsp.valid      = out_valid_q;
  assign rsp.hit        = out_hit_q;
  assign rsp.read_value = out_value_q;

`ifndef ASSERT_OFF
  // The fill count matches the number of valid entries
  a_used_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == int'(used_q))
    else $error("fill count differs from valid entries");

  // A key is held in at most one entry
  a_hit_unique: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> $onehot0(hit_oh))
    else $error("key matched in more than one entry");

  // Inserting a new key always finds exactly one slot
  a_slot_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (put_fire && !hit) |-> $onehot(slot_oh))
    else $error("no single slot for new key");

  // A result appears only after a get leaves the input register
  a_rsp_from_get: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(get_fire))
    else $error("result without a get");

  // A stalled result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !rsp.ready) |-> !get_fire)
    else $error("pending result overwritten");
`endif

endmodule

// ----- bench/lru_key_value_cache_unit_tb.sv -----
// Testbench for the LRU key-value cache: directed and random gets/puts checked against a mirror.
`timescale 1ns / 100ps

module lru_key_value_cache_unit_tb;

  localparam int Slots      = lkvc_pkg::Entries;
  localparam int KW         = lkvc_pkg::KeyBits;
  localparam int VW         = lkvc_pkg::ValueBits;
  localparam int CW         = lkvc_pkg::CapW;
  localparam int StallLimit = 5000;  // cycles without any accepted item
  localparam int HoldCycles = 300;   // long receiver hold-off
  localparam int SettleGap  = 4;     // a put can still be in flight after the last read

  typedef struct packed {
    logic          hit;
    logic [VW-1:0] data;
  } read_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  lkvc_req_if req_ch ();
  lkvc_rsp_if rsp_ch ();
  lkvc_cfg_if cfg_ch ();

  lru_key_value_cache_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req    (req_ch),
    .rsp    (rsp_ch),
    .cfg    (cfg_ch)
  );

  // Mirror of the cache contents and capacity register
  logic            m_valid [Slots];
  logic [KW-1:0]   m_key   [Slots];
  logic [VW-1:0]   m_value [Slots];
  int unsigned     m_age   [Slots];
  int unsigned     m_used;
  logic [CW-1:0]   m_capacity;

  read_result_t reads_due[$];
  logic [KW-1:0] key_pool [32];

  int err_count;
  int n_gets, n_hits, n_puts, n_evicts, n_cap_writes;
  int quiet_cycles;
  int stall_cycles;
  bit req_gaps, rsp_gaps;

  // Clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string what);
    err_count++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  function automatic void mirror_clear();
    for (int i = 0; i < Slots; i++) begin
      m_valid[i] = 1'b0;
      m_key[i]   = '0;
      m_value[i] = '0;
      m_age[i]   = 0;
    end
    m_used     = 0;
    m_capacity = lkvc_pkg::CapReset;
  endfunction

  // Entry i becomes most recent; younger entries age by one
  function automatic void mirror_touch(input int i);
    int unsigned a;
    a = m_age[i];
    for (int j = 0; j < Slots; j++)
      if (m_valid[j] && m_age[j] < a) m_age[j]++;
    m_age[i] = 0;
  endfunction

  // All other valid entries age, the slot takes the new key as most recent
  function automatic void mirror_fill(input int slot, input logic [KW-1:0] k,
                                      input logic [VW-1:0] v);
    for (int j = 0; j < Slots; j++)
      if (m_valid[j] && j != slot) m_age[j]++;
    m_valid[slot] = 1'b1;
    m_key[slot]   = k;
    m_value[slot] = v;
    m_age[slot]   = 0;
  endfunction

  // Apply one accepted item to the mirror; a get queues its expected read
  function automatic void mirror_access(input logic opc, input logic [KW-1:0] k,
                                        input logic [VW-1:0] v);
    int found;
    int slot;
    int unsigned lim;
    read_result_t r;
    found = -1;
    slot  = -1;
    for (int i = 0; i < Slots; i++)
      if (m_valid[i] && m_key[i] == k) found = i;
    if (opc == lkvc_pkg::OpGet) begin
      n_gets++;
      if (found >= 0) begin
        mirror_touch(found);
        r.hit  = 1'b1;
        r.data = m_value[found];
        n_hits++;
      end else begin
        r.hit  = 1'b0;
        r.data = '0;
      end
      reads_due.push_back(r);
      return;
    end
    n_puts++;
    if (found >= 0) begin
      m_value[found] = v;
      mirror_touch(found);
      return;
    end
    // Capacity zero acts as one, above the entry count it saturates
    lim = int'(m_capacity);
    if (lim < 1) lim = 1;
    if (lim > Slots) lim = Slots;
    if (m_used < lim) begin
      for (int j = Slots - 1; j >= 0; j--)
        if (!m_valid[j]) slot = j;
      if (slot >= 0) begin
        m_used++;
        mirror_fill(slot, k, v);
        return;
      end
    end
    // Evict the least recent entry
    for (int j = 0; j < Slots; j++)
      if (m_valid[j] && (slot < 0 || m_age[j] > m_age[slot])) slot = j;
    if (slot < 0) return;
    n_evicts++;
    m_valid[slot] = 1'b0;
    mirror_fill(slot, k, v);
  endfunction

  // Monitor: track config writes and requests, check every read item
  always @(posedge clk_i) begin
    read_result_t want;
    if (!rst_ni) begin
      mirror_clear();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) m_capacity = cfg_ch.data;
      if (req_ch.valid && req_ch.ready)
        mirror_access(req_ch.opcode, req_ch.key, req_ch.value);
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (reads_due.size() == 0) begin
          report_mismatch("read item with no get outstanding");
        end else begin
          want = reads_due.pop_front();
          if (rsp_ch.hit !== want.hit)
            report_mismatch($sformatf("hit %b, expected %b", rsp_ch.hit, want.hit));
          if (rsp_ch.read_value !== want.data)
            report_mismatch($sformatf("read_value %h, expected %h",
                                      rsp_ch.read_value, want.data));
        end
      end
    end
  end

  // Receiver: random idling plus an optional long hold-off
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rsp_ch.ready <= 1'b0;
    end else if (stall_cycles > 0) begin
      rsp_ch.ready <= 1'b0;
      stall_cycles--;
    end else begin
      rsp_ch.ready <= !(rsp_gaps && $urandom_range(99) < 23);
    end
  end

  // Watchdog: no item moving on any channel for too long
  always @(posedge clk_i) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("timeout: no item accepted for %0d cycles", StallLimit);
        $display("FAIL");
        $finish;
      end
    end
  end

  // Offer one request item and wait for it to be taken
  task automatic send_item(input logic opc, input logic [KW-1:0] k, input logic [VW-1:0] v);
    if (req_gaps && $urandom_range(99) < 23) begin
      req_ch.valid <= 1'b0;
      do @(posedge clk_i); while (req_gaps && $urandom_range(99) < 23);
    end
    req_ch.valid  <= 1'b1;
    req_ch.opcode <= opc;
    req_ch.key    <= k;
    req_ch.value  <= v;
    do @(posedge clk_i); while (!req_ch.ready);
  endtask

  // Stop offering, wait for all reads, then let an in-flight put finish
  task automatic settle_idle();
    req_ch.valid <= 1'b0;
    do @(posedge clk_i); while (reads_due.size() != 0);
    repeat (SettleGap) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [CW-1:0] c);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= c;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    n_cap_writes++;
  endtask

  function automatic logic [KW-1:0] pick_key(input int pool_n);
    if ($urandom_range(9) == 0) return $urandom;
    return key_pool[$urandom_range(pool_n - 1)];
  endfunction

  // Mostly keys from a small pool so gets hit and puts evict
  task automatic run_traffic(input int n, input int pool_n, input int hold_at);
    for (int i = 0; i < n; i++) begin
      if (i == hold_at) stall_cycles = HoldCycles;
      send_item(($urandom_range(99) < 45) ? lkvc_pkg::OpGet : lkvc_pkg::OpPut,
                pick_key(pool_n), $urandom);
    end
    settle_idle();
  endtask

  // Empty cache, key and value extremes, update in place
  task automatic test_basic_access();
    send_item(lkvc_pkg::OpGet, 32'h0000_0000, $urandom);
    send_item(lkvc_pkg::OpPut, 32'h8000_0000, 32'h7FFF_FFFF);
    send_item(lkvc_pkg::OpPut, 32'h7FFF_FFFF, 32'h8000_0000);
    send_item(lkvc_pkg::OpPut, 32'hFFFF_FFFF, 32'h0000_0000);
    send_item(lkvc_pkg::OpPut, 32'h0000_0000, 32'hFFFF_FFFF);
    send_item(lkvc_pkg::OpGet, 32'h8000_0000, $urandom);
    send_item(lkvc_pkg::OpGet, 32'h7FFF_FFFF, $urandom);
    send_item(lkvc_pkg::OpGet, 32'hFFFF_FFFF, $urandom);
    send_item(lkvc_pkg::OpGet, 32'h0000_0000, $urandom);
    send_item(lkvc_pkg::OpPut, 32'h7FFF_FFFF, 32'h0000_0001);
    send_item(lkvc_pkg::OpGet, 32'h7FFF_FFFF, $urandom);
    settle_idle();
  endtask

  // Capacity one with more entries held: each new key evicts the least recent entry
  task automatic test_capacity_one();
    write_capacity(5'd1);
    send_item(lkvc_pkg::OpPut, 32'h0000_1111, 32'hAAAA_0001);
    send_item(lkvc_pkg::OpPut, 32'h0000_2222, 32'hAAAA_0002);
    send_item(lkvc_pkg::OpGet, 32'h0000_1111, $urandom);
    send_item(lkvc_pkg::OpGet, 32'h0000_2222, $urandom);
    settle_idle();
  endtask

  // Capacity zero behaves as one
  task automatic test_capacity_zero();
    write_capacity(5'd0);
    send_item(lkvc_pkg::OpPut, 32'h0000_3333, 32'h5555_0003);
    send_item(lkvc_pkg::OpGet, 32'h0000_2222, $urandom);
    send_item(lkvc_pkg::OpGet, 32'h0000_3333, $urandom);
    settle_idle();
  endtask

  // A get refreshes recency, so the refreshed entry is not the victim
  task automatic test_lru_order();
    write_capacity(5'd2);
    send_item(lkvc_pkg::OpPut, 32'h0000_00A0, 32'h0000_000A);
    send_item(lkvc_pkg::OpPut, 32'h0000_00B0, 32'h0000_000B);
    send_item(lkvc_pkg::OpGet, 32'h0000_00A0, $urandom);
    send_item(lkvc_pkg::OpPut, 32'h0000_00C0, 32'h0000_000C);
    send_item(lkvc_pkg::OpGet, 32'h0000_00B0, $urandom);
    send_item(lkvc_pkg::OpGet, 32'h0000_00A0, $urandom);
    settle_idle();
  endtask

  // Register above the entry count: all entries used
  task automatic test_saturated_capacity();
    write_capacity(5'd31);
    run_traffic(300, 24, -1);
  endtask

  // Lowered below the entries in use: one eviction per new key
  task automatic test_shrunk_capacity();
    write_capacity(5'd3);
    run_traffic(200, 6, -1);
  endtask

  // Long receiver hold-off while requests keep coming
  task automatic test_output_stall();
    write_capacity(5'd16);
    run_traffic(200, 20, 40);
  endtask

  // Back-to-back items, no idling on either side
  task automatic test_no_idle();
    req_gaps = 1'b0;
    rsp_gaps = 1'b0;
    write_capacity(5'd8);
    run_traffic(300, 12, -1);
    req_gaps = 1'b1;
    rsp_gaps = 1'b1;
  endtask

  task automatic test_tiny_capacity();
    write_capacity(5'd0);
    run_traffic(150, 3, -1);
  endtask

  task automatic test_random_settings();
    for (int p = 0; p < 5; p++) begin
      write_capacity(CW'($urandom_range(31)));
      run_traffic(60, $urandom_range(32, 2), -1);
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    req_ch.valid  = 1'b0;
    req_ch.opcode = lkvc_pkg::OpGet;
    req_ch.key    = '0;
    req_ch.value  = '0;
    rsp_ch.ready  = 1'b0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.data   = '0;
    err_count     = 0;
    quiet_cycles  = 0;
    stall_cycles  = 0;
    req_gaps      = 1'b1;
    rsp_gaps      = 1'b1;
    for (int i = 0; i < 32; i++) key_pool[i] = $urandom;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_basic_access();
    test_capacity_one();
    test_capacity_zero();
    test_lru_order();
    test_saturated_capacity();
    test_shrunk_capacity();
    test_output_stall();
    test_no_idle();
    test_tiny_capacity();
    test_random_settings();

    repeat (8) @(posedge clk_i);
    $display("Ran %0d gets (%0d hits) and %0d puts, %0d of them evicting an entry.",
             n_gets, n_hits, n_puts, n_evicts);
    $display("Capacity was set %0d times, covering 0, 1, 16, 31 and random values.",
             n_cap_writes);
    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/lkvc_pkg.sv
rtl/lkvc_if.sv
rtl/lkvc_lookup.sv
rtl/lru_key_value_cache_unit.sv
bench/lru_key_value_cache_unit_tb.sv
